/* hdl/order_book_best_price_tracker_assert.svh */
// Assertion macros for the order book best price tracker.
// Used by the controller and the top level; no other dependencies.
`ifndef ORDER_BOOK_BEST_PRICE_TRACKER_ASSERT_SVH
`define ORDER_BOOK_BEST_PRICE_TRACKER_ASSERT_SVH
// property that must hold whenever reset is released
`define OB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked during reset too
`define OB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hdl/obt_pkg.sv */
// Package for the order book best price tracker: widths, request/result
// structs, controller/datapath command and status types. No dependencies.
package obt_pkg;
    localparam int ORDER_SLOTS   = 1024;
    localparam int PRICE_LEVELS  = 64;
    localparam int PRICE_BITS    = 16;
    localparam int QUANTITY_BITS = 24;
    localparam int TOTAL_BITS    = 32;
    localparam int SLOT_BITS     = $clog2(ORDER_SLOTS);
    localparam int LEVEL_BITS    = $clog2(PRICE_LEVELS);
    localparam int CNT_BITS      = $clog2(ORDER_SLOTS + PRICE_LEVELS);

    typedef struct packed {
        logic [SLOT_BITS-1:0]     order_number;
        logic                     side_is_bid;
        logic [PRICE_BITS-1:0]    price_ticks;
        logic [QUANTITY_BITS-1:0] order_quantity;
    } t_in;

    typedef struct packed {
        logic                  best_bid_present;
        logic [PRICE_BITS-1:0] best_bid_price;
        logic                  best_ask_present;
        logic [PRICE_BITS-1:0] best_ask_price;
        logic                  level_table_full;
    } t_out;

    typedef struct packed {
        logic clr;       // clear one order table entry after reset
        logic load;      // latch request, start order table read
        logic decode;    // order entry read data valid: set up operation
        logic scan_clr;  // reset scan accumulators
        logic scan_step; // read one level of each side
        logic tot_rd;    // read total of the found level
        logic apply;     // perform update on found/free level and order table
        logic best_clr;
        logic best_step;
    } t_cmd;

    typedef struct packed {
        logic skip;      // cancel of unknown order
    } t_sts;
endpackage

/* hdl/obt_datapath.sv */
// Datapath: order table memory, per-side level tables, level search and
// best price scan. Depends on obt_pkg.
module obt_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  obt_pkg::t_cmd  i_cmd,
    input  obt_pkg::t_in   i_req,
    input  logic [obt_pkg::LEVEL_BITS-1:0] i_idx,
    input  logic [obt_pkg::SLOT_BITS-1:0]  i_slot,
    output obt_pkg::t_sts  o_sts,
    output obt_pkg::t_out  o_res
);
    import obt_pkg::*;

    typedef struct packed {
        logic                     valid;
        logic                     side;
        logic [PRICE_BITS-1:0]    price;
        logic [QUANTITY_BITS-1:0] qty;
    } t_ord;

    t_ord r_omem [ORDER_SLOTS];
    t_ord r_ord_rd;
    logic w_known;

    logic [PRICE_LEVELS-1:0] r_bvalid, r_avalid;
    logic [PRICE_BITS-1:0] r_bprice [PRICE_LEVELS];
    logic [PRICE_BITS-1:0] r_aprice [PRICE_LEVELS];
    logic [TOTAL_BITS-1:0] r_btotal [PRICE_LEVELS];
    logic [TOTAL_BITS-1:0] r_atotal [PRICE_LEVELS];

    t_in r_req;
    logic r_side;
    logic [PRICE_BITS-1:0] r_price;
    logic r_found, r_has_free;
    logic [LEVEL_BITS-1:0] r_found_idx, r_free_idx;
    logic r_full;
    logic r_bp, r_ap;
    logic [PRICE_BITS-1:0] r_bbest, r_abest;

    logic r_scan_d, r_best_d;
    logic r_rd_bv, r_rd_av;
    logic [PRICE_BITS-1:0] r_rd_bp, r_rd_ap;
    logic [LEVEL_BITS-1:0] r_rd_idx;
    logic [TOTAL_BITS-1:0] r_tot_rd;

    assign w_known = r_ord_rd.valid;

    logic [SLOT_BITS-1:0] w_slot;
    assign w_slot = r_req.order_number[SLOT_BITS-1:0];

    logic                  w_lv;
    logic [PRICE_BITS-1:0] w_lp;
    assign w_lv = r_side ? r_rd_bv : r_rd_av;
    assign w_lp = r_side ? r_rd_bp : r_rd_ap;

    logic [TOTAL_BITS-1:0] w_tot, n_tot, w_old, w_new;
    logic [TOTAL_BITS:0]   w_sum;
    logic                  n_keep;
    assign w_tot = r_tot_rd;
    assign w_old = TOTAL_BITS'(r_ord_rd.qty);
    assign w_new = TOTAL_BITS'(r_req.order_quantity);

    always_comb begin
        n_keep = 1'b1;
        w_sum  = '0;
        n_tot  = w_tot;
        if (!w_known) begin
            w_sum = {1'b0, (r_found ? w_tot : '0)} + {1'b0, w_new};
            n_tot = w_sum[TOTAL_BITS] ? '1 : w_sum[TOTAL_BITS-1:0];
        end else if (r_req.order_quantity == '0) begin
            n_keep = w_tot > w_old;
            n_tot  = w_tot - w_old;
        end else if (w_new >= w_old) begin
            w_sum = {1'b0, w_tot} + {1'b0, w_new - w_old};
            n_tot = w_sum[TOTAL_BITS] ? '1 : w_sum[TOTAL_BITS-1:0];
        end else begin
            n_tot = (w_tot > w_old - w_new) ? w_tot - (w_old - w_new) : '0;
        end
    end

    logic [LEVEL_BITS-1:0] w_widx;
    assign w_widx = r_found ? r_found_idx : r_free_idx;

    assign o_sts.skip = !w_known && (r_req.order_quantity == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) r_omem[i_slot] <= '0;
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_ord_rd <= r_omem[i_req.order_number[SLOT_BITS-1:0]];
        end
        if (i_cmd.decode) begin
            r_side  <= w_known ? r_ord_rd.side : r_req.side_is_bid;
            r_price <= w_known ? r_ord_rd.price : r_req.price_ticks;
        end
        if (i_cmd.scan_clr) begin
            r_found    <= 1'b0;
            r_has_free <= 1'b0;
            r_full     <= 1'b0;
        end
        if (i_cmd.scan_step || i_cmd.best_step) begin
            r_rd_bv  <= r_bvalid[i_idx];
            r_rd_av  <= r_avalid[i_idx];
            r_rd_bp  <= r_bprice[i_idx];
            r_rd_ap  <= r_aprice[i_idx];
            r_rd_idx <= i_idx;
        end
        if (r_scan_d) begin
            if (w_lv && w_lp == r_price && !r_found) begin
                r_found     <= 1'b1;
                r_found_idx <= r_rd_idx;
            end
            if (!w_lv && !r_has_free) begin
                r_has_free <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
        end
        if (i_cmd.tot_rd)
            r_tot_rd <= r_side ? r_btotal[r_found_idx] : r_atotal[r_found_idx];
        if (i_cmd.apply) begin
            if (w_known) begin
                if (r_found) begin
                    if (r_side) r_btotal[r_found_idx] <= n_tot;
                    else        r_atotal[r_found_idx] <= n_tot;
                end
                if (r_req.order_quantity != '0)
                    r_omem[w_slot] <= '{1'b1, r_ord_rd.side, r_ord_rd.price,
                                        r_req.order_quantity};
                else
                    r_omem[w_slot] <= '0;
            end else if (r_found || r_has_free) begin
                if (r_side) begin
                    r_btotal[w_widx] <= n_tot;
                    r_bprice[w_widx] <= r_price;
                end else begin
                    r_atotal[w_widx] <= n_tot;
                    r_aprice[w_widx] <= r_price;
                end
                r_omem[w_slot] <= '{1'b1, r_req.side_is_bid, r_req.price_ticks,
                                    r_req.order_quantity};
            end else begin
                r_full <= 1'b1;
            end
        end
        if (i_cmd.best_clr) begin
            r_bp <= 1'b0; r_ap <= 1'b0; r_bbest <= '0; r_abest <= '0;
        end
        if (r_best_d) begin
            if (r_rd_bv && (!r_bp || r_rd_bp > r_bbest)) begin
                r_bp <= 1'b1; r_bbest <= r_rd_bp;
            end
            if (r_rd_av && (!r_ap || r_rd_ap < r_abest)) begin
                r_ap <= 1'b1; r_abest <= r_rd_ap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= '0;
            r_avalid <= '0;
            r_scan_d <= 1'b0;
            r_best_d <= 1'b0;
        end else begin
            r_scan_d <= i_cmd.scan_step;
            r_best_d <= i_cmd.best_step;
            if (i_cmd.apply) begin
                if (w_known) begin
                    if (r_found && !n_keep) begin
                        if (r_side) r_bvalid[r_found_idx] <= 1'b0;
                        else        r_avalid[r_found_idx] <= 1'b0;
                    end
                end else if (r_found || r_has_free) begin
                    if (r_side) r_bvalid[w_widx] <= 1'b1;
                    else        r_avalid[w_widx] <= 1'b1;
                end
            end
        end
    end

    assign o_res = '{r_bp, r_bbest, r_ap, r_abest, r_full};
endmodule

/* hdl/obt_ctrl.sv */
// Controller state machine: sequences order read, level search, update and
// best price scan; owns the handshakes. Depends on obt_pkg and the assert header.
`include "order_book_best_price_tracker_assert.svh"
module obt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  obt_pkg::t_sts i_sts,
    output obt_pkg::t_cmd o_cmd,
    output logic [obt_pkg::LEVEL_BITS-1:0] o_idx,
    output logic [obt_pkg::SLOT_BITS-1:0]  o_slot
);
    import obt_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_FIND, S_FWAIT, S_TOT, S_APPLY, S_BEST, S_BWAIT, S_OUT
    } t_state;
    t_state r_state;
    logic [CNT_BITS-1:0] r_cnt;
    logic r_out_valid;

    assign o_idx       = r_cnt[LEVEL_BITS-1:0];
    assign o_slot      = r_cnt[SLOT_BITS-1:0];
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLR:   o_cmd.clr = 1'b1;
            S_IDLE:  o_cmd.load = i_in_valid;
            S_DEC:   begin o_cmd.decode = 1'b1; o_cmd.scan_clr = 1'b1; end
            S_FIND:  o_cmd.scan_step = 1'b1;
            S_FWAIT: o_cmd = '0;
            S_TOT:   o_cmd.tot_rd = 1'b1;
            S_APPLY: begin o_cmd.apply = 1'b1; o_cmd.best_clr = 1'b1; end
            S_BEST:  o_cmd.best_step = 1'b1;
            S_BWAIT: o_cmd = '0;
            S_OUT:   o_cmd = '0;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    if (r_cnt == CNT_BITS'(ORDER_SLOTS - 1)) begin
                        r_cnt <= '0; r_state <= S_IDLE;
                    end else r_cnt <= r_cnt + 1'b1;
                end
                S_IDLE: if (i_in_valid) r_state <= S_DEC;
                S_DEC: begin
                    r_cnt   <= '0;
                    r_state <= i_sts.skip ? S_IDLE : S_FIND;
                end
                S_FIND: begin
                    if (r_cnt == CNT_BITS'(PRICE_LEVELS - 1)) begin
                        r_cnt <= '0; r_state <= S_FWAIT;
                    end else r_cnt <= r_cnt + 1'b1;
                end
                S_FWAIT: r_state <= S_TOT;
                S_TOT:   r_state <= S_APPLY;
                S_APPLY: r_state <= S_BEST;
                S_BEST: begin
                    if (r_cnt == CNT_BITS'(PRICE_LEVELS - 1)) begin
                        r_cnt <= '0; r_state <= S_BWAIT;
                    end else r_cnt <= r_cnt + 1'b1;
                end
                S_BWAIT: begin
                    r_state <= S_OUT; r_out_valid <= 1'b1;
                end
                S_OUT: if (!i_out_stall) begin
                    r_out_valid <= 1'b0; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `OB_ASSERT(a_out_only_in_out, i_clk, i_rst_n, r_out_valid |-> r_state == S_OUT, "result outside output state")
    `OB_ASSERT(a_apply_once, i_clk, i_rst_n, o_cmd.apply |=> !o_cmd.apply, "apply repeated")
    `OB_ASSERT(a_load_idle, i_clk, i_rst_n, o_cmd.load |-> !o_in_stall, "load while busy")
endmodule

/* hdl/order_book_best_price_tracker.sv */
// Order book best price tracker top level: controller plus datapath.
// An accepted request goes through a level search and a best price scan over the
// price level tables, each on registered table reads; the input is stalled until the
// result is taken, so one request is handled at a time. A cancel of an unknown order
// gives no result. Synchronous active-low reset clears level valid bits, then a pass
// clears the order table while the input is stalled.
`include "order_book_best_price_tracker_assert.svh"
module order_book_best_price_tracker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  obt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output obt_pkg::t_out o_out_data
);
    import obt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic [LEVEL_BITS-1:0] w_idx;
    logic [SLOT_BITS-1:0]  w_slot;

    obt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall), .i_sts(w_sts), .o_cmd(w_cmd), .o_idx(w_idx),
        .o_slot(w_slot)
    );

    obt_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_req(i_in_data),
        .i_idx(w_idx), .i_slot(w_slot), .o_sts(w_sts), .o_res(o_out_data)
    );

    `OB_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result changed")
    `OB_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
endmodule

/* test/order_book_best_price_tracker_test.sv */
// Testbench for the order book best price tracker: drives order events
// (new, modify, cancel) and checks best bid/ask and the table full flag against a behavioral book.
// Depends on obt_pkg and the order_book_best_price_tracker RTL.
module order_book_best_price_tracker_test;
    import obt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    class book_scoreboard;
        bit            live[ORDER_SLOTS];
        bit            side_of[ORDER_SLOTS];
        bit [15:0]     price_of[ORDER_SLOTS];
        bit [23:0]     qty_of[ORDER_SLOTS];
        bit            bid_used[PRICE_LEVELS];
        bit [15:0]     bid_px[PRICE_LEVELS];
        bit [31:0]     bid_tot[PRICE_LEVELS];
        bit            ask_used[PRICE_LEVELS];
        bit [15:0]     ask_px[PRICE_LEVELS];
        bit [31:0]     ask_tot[PRICE_LEVELS];
        t_out          pending_quotes[$];
        int            mismatches;

        function bit [31:0] add_sat(bit [31:0] a, bit [31:0] b);
            bit [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        // apply one request to the book; queue the expected quote unless it cancels an unknown order
        function void note_request(t_in r);
            int        slot;
            int        lv;
            bit        bid;
            bit        full;
            bit [31:0] old;
            bit [31:0] nq;
            t_out      q;
            slot = r.order_number;
            nq = 32'(r.order_quantity);
            lv = -1;
            full = 1'b0;
            if (live[slot]) begin
                bid = side_of[slot];
                old = 32'(qty_of[slot]);
                for (int i = PRICE_LEVELS - 1; i >= 0; i--) begin
                    if (bid ? (bid_used[i] && bid_px[i] == price_of[slot])
                            : (ask_used[i] && ask_px[i] == price_of[slot])) lv = i;
                end
                if (nq == 0) begin
                    if (lv >= 0) begin
                        if (bid) begin
                            if (bid_tot[lv] <= old) bid_used[lv] = 1'b0;
                            else bid_tot[lv] -= old;
                        end else begin
                            if (ask_tot[lv] <= old) ask_used[lv] = 1'b0;
                            else ask_tot[lv] -= old;
                        end
                    end
                    live[slot] = 1'b0;
                end else begin
                    if (lv >= 0) begin
                        if (bid) begin
                            if (nq >= old) bid_tot[lv] = add_sat(bid_tot[lv], nq - old);
                            else bid_tot[lv] = bid_tot[lv] > old - nq ?
                                bid_tot[lv] - (old - nq) : '0;
                        end else begin
                            if (nq >= old) ask_tot[lv] = add_sat(ask_tot[lv], nq - old);
                            else ask_tot[lv] = ask_tot[lv] > old - nq ?
                                ask_tot[lv] - (old - nq) : '0;
                        end
                    end
                    qty_of[slot] = r.order_quantity;
                end
            end else begin
                if (nq == 0) return;
                bid = r.side_is_bid;
                for (int i = PRICE_LEVELS - 1; i >= 0; i--) begin
                    if (bid ? (bid_used[i] && bid_px[i] == r.price_ticks)
                            : (ask_used[i] && ask_px[i] == r.price_ticks)) lv = i;
                end
                if (lv < 0) begin
                    for (int i = PRICE_LEVELS - 1; i >= 0; i--) begin
                        if (bid ? !bid_used[i] : !ask_used[i]) lv = i;
                    end
                    if (lv >= 0) begin
                        if (bid) begin
                            bid_used[lv] = 1'b1; bid_px[lv] = r.price_ticks; bid_tot[lv] = '0;
                        end else begin
                            ask_used[lv] = 1'b1; ask_px[lv] = r.price_ticks; ask_tot[lv] = '0;
                        end
                    end
                end
                if (lv < 0) begin
                    full = 1'b1;
                end else begin
                    if (bid) bid_tot[lv] = add_sat(bid_tot[lv], nq);
                    else ask_tot[lv] = add_sat(ask_tot[lv], nq);
                    live[slot] = 1'b1;
                    side_of[slot] = bid;
                    price_of[slot] = r.price_ticks;
                    qty_of[slot] = r.order_quantity;
                end
            end
            q = '0;
            q.level_table_full = full;
            for (int i = 0; i < PRICE_LEVELS; i++) begin
                if (bid_used[i] && (!q.best_bid_present || bid_px[i] > q.best_bid_price)) begin
                    q.best_bid_present = 1'b1;
                    q.best_bid_price = bid_px[i];
                end
                if (ask_used[i] && (!q.best_ask_present || ask_px[i] < q.best_ask_price)) begin
                    q.best_ask_present = 1'b1;
                    q.best_ask_price = ask_px[i];
                end
            end
            pending_quotes.push_back(q);
        endfunction

        function void check_quote(t_out got);
            t_out e;
            if (pending_quotes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending_quotes.pop_front();
            if (got.best_bid_present !== e.best_bid_present
                    || got.best_bid_price !== e.best_bid_price
                    || got.best_ask_present !== e.best_ask_present
                    || got.best_ask_price !== e.best_ask_price
                    || got.level_table_full !== e.level_table_full) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p got %p", e, got);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_stall;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 0;
    t_out o_out_data;

    book_scoreboard book = new();
    bit   sending_done = 0;
    bit   calm = 0;
    bit   hold_off = 0;
    int   idle_cycles = 0;
    int   live_ids[$];

    order_book_best_price_tracker dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // book-keeping on accepted handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) book.note_request(i_in_data);
            if (o_out_valid && !i_out_stall) book.check_quote(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress");
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else i_out_stall <= !calm && ($urandom_range(99) < 13);
    end

    // long hold-off once the order table clearing pass is over
    initial begin
        repeat (1600) @(posedge i_clk);
        hold_off = 1;
        repeat (600) @(posedge i_clk);
        hold_off = 0;
    end

    task automatic send_request(t_in r);
        if (!calm) begin
            while ($urandom_range(99) < 13) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_event(bit [9:0] id, bit bid, bit [15:0] px, bit [23:0] qty);
        t_in r;
        r.order_number = id;
        r.side_is_bid = bid;
        r.price_ticks = px;
        r.order_quantity = qty;
        send_request(r);
    endtask

    task automatic random_event();
        int pick;
        bit [9:0] id;
        pick = $urandom_range(99);
        if (live_ids.size() > 0 && pick < 35) begin
            id = 10'(live_ids[$urandom_range(live_ids.size() - 1)]);
            send_event(id, 1'($urandom), 16'($urandom),
                $urandom_range(1) ? 24'd0 : 24'($urandom_range(9) == 0 ? 24'hFFFFFF : $urandom));
        end else if (pick < 40) begin
            send_event(10'($urandom), 1'($urandom), 16'($urandom), 24'($urandom));
        end else begin
            id = 10'($urandom);
            send_event(id, 1'($urandom), 16'(($urandom_range(1) ? 16'd1000 : 16'd60000)
                + $urandom_range(90)),
                $urandom_range(9) == 0 ? 24'hFFFFFF : 24'($urandom_range(500)));
            live_ids.push_back(id);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, modify, cancel, unknown cancel, large totals
        send_event(10'd0, 1, 16'd0, 24'd1);
        send_event(10'd1023, 0, 16'hFFFF, 24'hFFFFFF);
        send_event(10'd5, 0, 16'd0, 24'd0);
        send_event(10'd2, 1, 16'hFFFF, 24'hFFFFFF);
        for (int k = 0; k < 20; k++) send_event(10'(100 + k), 1, 16'hFFFF, 24'hFFFFFF);
        send_event(10'd2, 0, 16'd3, 24'd5);
        send_event(10'd2, 0, 16'd3, 24'hFFFFFF);
        send_event(10'd0, 1, 16'd9, 24'd7);
        send_event(10'd0, 1, 16'd9, 24'd0);
        send_event(10'd0, 1, 16'd9, 24'd0);
        send_event(10'd2, 1, 16'd0, 24'd0);
        send_event(10'd1023, 1, 16'd0, 24'd0);
        send_event(10'd3, 0, 16'hAAAA, 24'h555555);
        send_event(10'd3, 0, 16'd0, 24'd0);
        for (int k = 0; k < 20; k++) send_event(10'(100 + k), 0, 16'd0, 24'd0);
        // fill the ask table, then overflow it
        for (int k = 0; k < PRICE_LEVELS + 2; k++)
            send_event(10'(500 + k), 0, 16'(2000 + k), 24'd3);
        for (int k = 0; k < PRICE_LEVELS + 2; k++)
            send_event(10'(500 + k), 0, 16'd0, 24'd0);
        for (int k = 0; k < 80; k++) random_event();
        calm = 1;
        for (int k = 0; k < 60; k++) random_event();
        calm = 0;
        for (int k = 0; k < 80; k++) random_event();
        i_in_valid <= 1'b0;
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        while (book.pending_quotes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/obt_pkg.sv
hdl/obt_datapath.sv
hdl/obt_ctrl.sv
hdl/order_book_best_price_tracker.sv
test/order_book_best_price_tracker_test.sv
